// ----- design/utf8_word_segment_marker_macros.svh -----
// Assertion macros shared by the utf8 word segment marker RTL.
`ifndef UTF8_WORD_SEGMENT_MARKER_MACROS_SVH
`define UTF8_WORD_SEGMENT_MARKER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define UWSM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("utf8ws: check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define UWSM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("utf8ws: check failed");

`endif

// ----- design/utf8ws_pkg.sv -----
// Types, codes and character class tables of the utf8 word segment marker.
`default_nettype none
package utf8ws_pkg;

  localparam int CP_W  = 21;
  localparam int LEN_W = 3;

  typedef enum logic [1:0] {
    CLS_SEP  = 2'd0,
    CLS_WORD = 2'd1,
    CLS_CJK  = 2'd2
  } char_class_t;

  // Results caused by one byte: a run of malformed units, then an optional tail unit.
  typedef struct packed {
    logic [1:0]       flush_n;
    logic             flush_bnd;
    logic             tail_vld;
    logic [CP_W-1:0]  tail_cp;
    logic [LEN_W-1:0] tail_len;
    logic             tail_bad;
    char_class_t      tail_cls;
    logic             tail_bnd;
  } burst_t;

  function automatic logic in_span(input logic [CP_W-1:0] cp, input logic [CP_W-1:0] lo,
                                   input logic [CP_W-1:0] hi);
    in_span = (cp >= lo) && (cp <= hi);
  endfunction

  function automatic logic is_cjk(input logic [CP_W-1:0] cp);
    logic hit;
    hit = in_span(cp, 21'h03040, 21'h0309F) || in_span(cp, 21'h030A0, 21'h030FF) ||
          in_span(cp, 21'h03400, 21'h04DBF) || in_span(cp, 21'h04E00, 21'h09FFF) ||
          in_span(cp, 21'h0AC00, 21'h0D7AF) || in_span(cp, 21'h0F900, 21'h0FAFF) ||
          in_span(cp, 21'h0FF01, 21'h0FF5E) || in_span(cp, 21'h031F0, 21'h031FF) ||
          in_span(cp, 21'h20000, 21'h2FA1F);
    // CJK punctuation points
    hit = hit || in_span(cp, 21'h03008, 21'h0301C) || in_span(cp, 21'h03001, 21'h03002) ||
          in_span(cp, 21'h03005, 21'h03006) || (cp == 21'h0303B) ||
          (cp == 21'h02010) || (cp == 21'h02013) || in_span(cp, 21'h02018, 21'h02019) ||
          in_span(cp, 21'h0201C, 21'h0201D) || (cp == 21'h0203C) ||
          in_span(cp, 21'h02047, 21'h02049) || in_span(cp, 21'h0FF60, 21'h0FF64);
    // 0x3012 and 0x3013 sit inside the range above but are not in the list
    if ((cp == 21'h03012) || (cp == 21'h03013)) begin
      hit = in_span(cp, 21'h03040, 21'h0309F);
    end
    is_cjk = hit;
  endfunction

  function automatic char_class_t classify(input logic [CP_W-1:0] cp);
    char_class_t c;
    if (is_cjk(cp)) begin
      c = CLS_CJK;
    end else if (cp < 21'h00080) begin
      c = (in_span(cp, 21'h30, 21'h39) || in_span(cp, 21'h41, 21'h5A) ||
           in_span(cp, 21'h61, 21'h7A) || (cp == 21'h5F)) ? CLS_WORD : CLS_SEP;
    end else if (in_span(cp, 21'h02000, 21'h0206F) || in_span(cp, 21'h03000, 21'h0303F) ||
                 in_span(cp, 21'h000A0, 21'h000BF) || (cp == 21'h000D7) ||
                 (cp == 21'h000F7)) begin
      c = CLS_SEP;
    end else begin
      c = CLS_WORD;
    end
    classify = c;
  endfunction

endpackage
`default_nettype wire

// ----- design/utf8ws_decode.sv -----
// Byte decoder state and per-byte result burst of the utf8 word segment marker.
`default_nettype none
module utf8ws_decode
  import utf8ws_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_text,
  output burst_t          burst
);

  logic [CP_W-1:0] part_r, part_nxt;
  logic [2:0]      exp_r, exp_nxt;
  logic [1:0]      rcv_r, rcv_nxt;
  char_class_t     prev_r, prev_nxt;
  logic            start_r, start_nxt;

  logic            pend, cont, complete;
  logic [2:0]      rcv_inc;
  logic [CP_W-1:0] part_cont;
  char_class_t     cls, prev_eff;
  logic            start_eff;

  assign pend      = (exp_r != 3'd0);
  assign cont      = (data_byte[7:6] == 2'b10);
  assign rcv_inc   = {1'b0, rcv_r} + 3'd1;
  assign complete  = ((rcv_inc + 3'd1) >= exp_r);
  assign part_cont = {part_r[CP_W-7:0], data_byte[5:0]};

  always_comb begin
    burst          = '0;
    burst.tail_cls = CLS_SEP;
    exp_nxt        = exp_r;
    rcv_nxt        = rcv_r;
    part_nxt       = part_r;
    if (pend && cont) begin
      if (complete) begin
        burst.tail_vld = 1'b1;
        burst.tail_cp  = part_cont;
        burst.tail_len = exp_r;
        exp_nxt        = 3'd0;
        rcv_nxt        = 2'd0;
        part_nxt       = '0;
      end else begin
        rcv_nxt  = rcv_inc[1:0];
        part_nxt = part_cont;
        if (end_of_text) begin
          burst.flush_n = rcv_inc[1:0] + 2'd1;
        end
      end
    end else begin
      if (pend) begin
        // broken sequence: lead and received continuations go out malformed
        burst.flush_n = rcv_r + 2'd1;
        exp_nxt       = 3'd0;
        rcv_nxt       = 2'd0;
        part_nxt      = '0;
      end
      burst.tail_len = 3'd1;
      if (!data_byte[7]) begin
        burst.tail_vld = 1'b1;
        burst.tail_cp  = {{(CP_W-8){1'b0}}, data_byte};
      end else if (end_of_text || cont || (data_byte[7:3] == 5'b11111)) begin
        burst.tail_vld = 1'b1;
        burst.tail_bad = 1'b1;
      end else begin
        rcv_nxt = 2'd0;
        priority if (data_byte[7:5] == 3'b110) begin
          exp_nxt  = 3'd2;
          part_nxt = {{(CP_W-5){1'b0}}, data_byte[4:0]};
        end else if (data_byte[7:4] == 4'b1110) begin
          exp_nxt  = 3'd3;
          part_nxt = {{(CP_W-4){1'b0}}, data_byte[3:0]};
        end else begin
          exp_nxt  = 3'd4;
          part_nxt = {{(CP_W-3){1'b0}}, data_byte[2:0]};
        end
      end
    end

    // malformed units are separators; only the first can open a segment
    burst.flush_bnd = start_r || (prev_r != CLS_SEP);
    prev_eff  = (burst.flush_n != 2'd0) ? CLS_SEP : prev_r;
    start_eff = (burst.flush_n != 2'd0) ? 1'b0 : start_r;
    cls       = classify(burst.tail_cp);
    burst.tail_cls = cls;
    burst.tail_bnd = start_eff || (cls == CLS_CJK) || (prev_eff == CLS_CJK) ||
                     ((cls == CLS_SEP) != (prev_eff == CLS_SEP));

    prev_nxt  = burst.tail_vld ? cls : prev_eff;
    start_nxt = (burst.tail_vld || (burst.flush_n != 2'd0)) ? 1'b0 : start_r;
    if (end_of_text) begin
      exp_nxt   = 3'd0;
      rcv_nxt   = 2'd0;
      part_nxt  = '0;
      prev_nxt  = CLS_SEP;
      start_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_r  <= '0;
      exp_r   <= 3'd0;
      rcv_r   <= 2'd0;
      prev_r  <= CLS_SEP;
      start_r <= 1'b1;
    end else if (accept) begin
      part_r  <= part_nxt;
      exp_r   <= exp_nxt;
      rcv_r   <= rcv_nxt;
      prev_r  <= prev_nxt;
      start_r <= start_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- design/utf8_word_segment_marker.sv -----
// Top level: UTF-8 decoder with word segment marks and result serializer.
//
// Input channel in_*: one raw text byte per item in in_tdata, in_tlast set on
// the final byte of a text. Result channel out_*: one decoded unit per item,
// out_tlast set on the final unit caused by an input byte. A byte gives zero to
// four units: none while a multi-byte sequence is still being gathered, several
// when a broken or truncated sequence is flushed as malformed single-byte units.
// Latency: a byte's first unit is presented the cycle after the byte is taken.
// Throughput: one byte per cycle while each byte gives at most one unit and the
// receiver takes each; the result register hands out one unit per cycle, so a
// byte with several units holds the input until its last unit leaves.
// The result register is the only buffering: when the receiver stalls, the
// current unit holds; in_tready stays low while more than one unit is pending
// and, on the last pending unit, follows out_tready.
// Reset (rst_n low, synchronous) clears any pending sequence and pending
// results and starts a new text; in_tlast does the same for the next byte.
`default_nettype none
`include "utf8_word_segment_marker_macros.svh"
module utf8_word_segment_marker
  import utf8ws_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,   // end_of_text
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [20:0] code_point, [23:21] unit_length, [24] malformed, [26:25] char_class,
  // [27] boundary_before, [31:28] zero
  output logic [31:0]      out_tdata,
  output logic             out_tlast   // last_of_run
);

  burst_t burst;
  logic   in_acc, out_acc, buf_empty, last_one;

  logic [1:0]       flush_left_r;
  logic             flush_bnd_r;
  logic             tail_vld_r;
  logic [CP_W-1:0]  tail_cp_r;
  logic [LEN_W-1:0] tail_len_r;
  logic             tail_bad_r;
  char_class_t      tail_cls_r;
  logic             tail_bnd_r;

  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;
  assign buf_empty = (flush_left_r == 2'd0) && !tail_vld_r;
  assign last_one  = ((flush_left_r == 2'd0) && tail_vld_r) ||
                     ((flush_left_r == 2'd1) && !tail_vld_r);
  assign in_tready = buf_empty || (last_one && out_tready);

  utf8ws_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_acc),
    .data_byte   (in_tdata),
    .end_of_text (in_tlast),
    .burst       (burst)
  );

  assign out_tvalid = !buf_empty;

  always_comb begin
    if (flush_left_r != 2'd0) begin
      out_tdata = {4'd0, flush_bnd_r, CLS_SEP, 1'b1, 3'd1, {CP_W{1'b0}}};
      out_tlast = (flush_left_r == 2'd1) && !tail_vld_r;
    end else begin
      out_tdata = {4'd0, tail_bnd_r, tail_cls_r, tail_bad_r, tail_len_r, tail_cp_r};
      out_tlast = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flush_left_r <= 2'd0;
      tail_vld_r   <= 1'b0;
    end else if (in_acc) begin
      flush_left_r <= burst.flush_n;
      tail_vld_r   <= burst.tail_vld;
    end else if (out_acc) begin
      if (flush_left_r != 2'd0) begin
        flush_left_r <= flush_left_r - 2'd1;
      end else begin
        tail_vld_r <= 1'b0;
      end
    end
  end

  // payload: load on a new item, drop the boundary mark after the first flushed unit
  always_ff @(posedge clk) begin
    if (in_acc) begin
      flush_bnd_r <= burst.flush_bnd;
      tail_cp_r   <= burst.tail_cp;
      tail_len_r  <= burst.tail_len;
      tail_bad_r  <= burst.tail_bad;
      tail_cls_r  <= burst.tail_cls;
      tail_bnd_r  <= burst.tail_bnd;
    end else if (out_acc && (flush_left_r != 2'd0)) begin
      flush_bnd_r <= 1'b0;
    end
  end

  `UWSM_ASSERT_NXT(a_run_continues, out_acc && !out_tlast, out_tvalid)
  `UWSM_ASSERT_IMP(a_load_on_last, in_acc && out_tvalid, out_tready && out_tlast)
  `UWSM_ASSERT_IMP(a_bad_unit_form, out_tvalid && (flush_left_r != 2'd0),
                   (out_tdata[23:0] == {3'd1, {CP_W{1'b0}}}) && (out_tdata[26:25] == CLS_SEP))
  `UWSM_ASSERT_NXT(a_single_flush_mark, out_acc && (flush_left_r != 2'd0) && !in_acc,
                   !flush_bnd_r)

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking testbench for the UTF-8 word segment marker.
`timescale 1ns / 1ps
module tb_top;
  import utf8ws_pkg::*;

  localparam int CYCLE_LIMIT = 100000;
  localparam int MAX_SHOWN   = 10;

  typedef struct packed {
    logic [20:0] cp;
    logic [2:0]  len;
    logic        bad;
    char_class_t cls;
    logic        bnd;
    logic        last;
  } unit_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;

  utf8_word_segment_marker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // decoder state mirrored by the predictor
  logic [20:0] gather_val;
  logic [2:0]  gather_len;
  logic [1:0]  gather_cnt;
  char_class_t prior_cls;
  logic        text_start;

  unit_t units_due[$];
  unit_t step_units[$];
  int    bad_units;
  int    bytes_sent;
  int    cycles;
  int    send_gap_pct;
  int    recv_stall_pct;

  function automatic logic is_cjk_point(input logic [20:0] cp);
    logic hit;
    hit = (cp >= 21'h03040 && cp <= 21'h030FF) || (cp >= 21'h03400 && cp <= 21'h04DBF) ||
          (cp >= 21'h04E00 && cp <= 21'h09FFF) || (cp >= 21'h0AC00 && cp <= 21'h0D7AF) ||
          (cp >= 21'h0F900 && cp <= 21'h0FAFF) || (cp >= 21'h0FF01 && cp <= 21'h0FF5E) ||
          (cp >= 21'h031F0 && cp <= 21'h031FF) || (cp >= 21'h20000 && cp <= 21'h2FA1F);
    case (cp)
      21'h03001, 21'h03002, 21'h03005, 21'h03006, 21'h03008, 21'h03009, 21'h0300A,
      21'h0300B, 21'h0300C, 21'h0300D, 21'h0300E, 21'h0300F, 21'h03010, 21'h03011,
      21'h03014, 21'h03015, 21'h03016, 21'h03017, 21'h03018, 21'h03019, 21'h0301A,
      21'h0301B, 21'h0301C, 21'h0303B, 21'h02010, 21'h02013, 21'h02018, 21'h02019,
      21'h0201C, 21'h0201D, 21'h0203C, 21'h02047, 21'h02048, 21'h02049, 21'h0FF60,
      21'h0FF61, 21'h0FF62, 21'h0FF63, 21'h0FF64: hit = 1'b1;
      default: ;
    endcase
    return hit;
  endfunction

  function automatic char_class_t class_of_point(input logic [20:0] cp);
    if (is_cjk_point(cp)) return CLS_CJK;
    if (cp < 21'h80) begin
      if ((cp >= 21'h30 && cp <= 21'h39) || (cp >= 21'h41 && cp <= 21'h5A) ||
          (cp >= 21'h61 && cp <= 21'h7A) || cp == 21'h5F) return CLS_WORD;
      return CLS_SEP;
    end
    if ((cp >= 21'h02000 && cp <= 21'h0206F) || (cp >= 21'h03000 && cp <= 21'h0303F) ||
        (cp >= 21'h000A0 && cp <= 21'h000BF) || cp == 21'h000D7 || cp == 21'h000F7)
      return CLS_SEP;
    return CLS_WORD;
  endfunction

  task automatic mark_unit(input logic [20:0] cp, input logic [2:0] len, input logic bad);
    unit_t u;
    u.cp   = cp;
    u.len  = len;
    u.bad  = bad;
    u.cls  = class_of_point(cp);
    u.bnd  = text_start || u.cls == CLS_CJK || prior_cls == CLS_CJK ||
             ((u.cls == CLS_SEP) != (prior_cls == CLS_SEP));
    u.last = 1'b0;
    prior_cls  = u.cls;
    text_start = 1'b0;
    step_units.push_back(u);
  endtask

  // emit the lead and each gathered continuation as malformed bytes
  task automatic flush_gathered();
    int i;
    mark_unit(21'd0, 3'd1, 1'b1);
    for (i = 0; i < gather_cnt; i++) mark_unit(21'd0, 3'd1, 1'b1);
    gather_len = 3'd0;
    gather_cnt = 2'd0;
    gather_val = 21'd0;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eot);
    logic        fresh;
    int          i;
    unit_t       u;
    fresh = 1'b1;
    step_units.delete();
    if (gather_len != 3'd0) begin
      if (b[7:6] == 2'b10) begin
        fresh      = 1'b0;
        gather_val = {gather_val[14:0], b[5:0]};
        gather_cnt = gather_cnt + 2'd1;
        if ({1'b0, gather_cnt} + 3'd1 >= gather_len) begin
          mark_unit(gather_val, gather_len, 1'b0);
          gather_len = 3'd0;
          gather_cnt = 2'd0;
          gather_val = 21'd0;
        end else if (eot) begin
          flush_gathered();
        end
      end else begin
        flush_gathered();
      end
    end
    if (fresh) begin
      if (b[7] == 1'b0) begin
        mark_unit({13'd0, b}, 3'd1, 1'b0);
      end else if (eot || b[7:6] == 2'b10 || b[7:3] == 5'b11111) begin
        mark_unit(21'd0, 3'd1, 1'b1);
      end else if (b[7:5] == 3'b110) begin
        gather_len = 3'd2; gather_cnt = 2'd0; gather_val = {16'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        gather_len = 3'd3; gather_cnt = 2'd0; gather_val = {17'd0, b[3:0]};
      end else begin
        gather_len = 3'd4; gather_cnt = 2'd0; gather_val = {18'd0, b[2:0]};
      end
    end
    for (i = 0; i < step_units.size(); i++) begin
      u      = step_units[i];
      u.last = (i == step_units.size() - 1);
      units_due.push_back(u);
    end
    if (eot) begin
      gather_val = 21'd0;
      gather_len = 3'd0;
      gather_cnt = 2'd0;
      prior_cls  = CLS_SEP;
      text_start = 1'b1;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    unit_t want;
    unit_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.cp   = out_tdata[20:0];
      got.len  = out_tdata[23:21];
      got.bad  = out_tdata[24];
      got.cls  = char_class_t'(out_tdata[26:25]);
      got.bnd  = out_tdata[27];
      got.last = out_tlast;
      if (units_due.size() == 0) begin
        if (bad_units < MAX_SHOWN)
          $display("unexpected unit: cp=%h len=%0d bad=%b cls=%0d bnd=%b last=%b",
                   got.cp, got.len, got.bad, got.cls, got.bnd, got.last);
        bad_units++;
      end else begin
        want = units_due.pop_front();
        if (got !== want || out_tdata[31:28] !== 4'd0) begin
          if (bad_units < MAX_SHOWN) begin
            $display("unit mismatch at cycle %0d", cycles);
            $display("  expected cp=%h len=%0d bad=%b cls=%0d bnd=%b last=%b pad=0",
                     want.cp, want.len, want.bad, want.cls, want.bnd, want.last);
            $display("  actual   cp=%h len=%0d bad=%b cls=%0d bnd=%b last=%b pad=%h",
                     got.cp, got.len, got.bad, got.cls, got.bnd, got.last,
                     out_tdata[31:28]);
          end
          bad_units++;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eot);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eot;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_byte(b, eot);
    bytes_sent++;
  endtask

  // hold off the sender until every predicted unit has come back
  task automatic drain_units();
    in_tvalid <= 1'b0;
    while (units_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_char(input logic [20:0] cp, input int len, input logic eot);
    case (len)
      1: send_byte({1'b0, cp[6:0]}, eot);
      2: begin
        send_byte({3'b110, cp[10:6]}, 1'b0);
        send_byte({2'b10, cp[5:0]}, eot);
      end
      3: begin
        send_byte({4'b1110, cp[15:12]}, 1'b0);
        send_byte({2'b10, cp[11:6]}, 1'b0);
        send_byte({2'b10, cp[5:0]}, eot);
      end
      default: begin
        send_byte({5'b11110, cp[20:18]}, 1'b0);
        send_byte({2'b10, cp[17:12]}, 1'b0);
        send_byte({2'b10, cp[11:6]}, 1'b0);
        send_byte({2'b10, cp[5:0]}, eot);
      end
    endcase
  endtask

  function automatic logic [20:0] pick_near_edge();
    case ($urandom_range(15))
      0:  return 21'h03012;
      1:  return 21'h03013;
      2:  return 21'h0303B;
      3:  return 21'h0301C;
      4:  return 21'h02010 + 21'($urandom_range(63));
      5:  return 21'h0206F + 21'($urandom_range(1));
      6:  return 21'h0FF00 + 21'($urandom_range(111));
      7:  return 21'h03000 + 21'($urandom_range(63));
      8:  return 21'h0309F + 21'($urandom_range(1));
      9:  return 21'h09FFF + 21'($urandom_range(1));
      10: return 21'h0D7AF + 21'($urandom_range(1));
      11: return 21'h031EF + 21'($urandom_range(1));
      12: return 21'h0F8FF + 21'($urandom_range(1));
      13: return 21'h0FAFF + 21'($urandom_range(1));
      14: return 21'h000D7;
      default: return 21'h000F7;
    endcase
  endfunction

  // mostly well-formed characters, with stray bytes and broken sequences mixed in
  task automatic send_random_text(input int count);
    int          stop_at;
    int          kind;
    int          len;
    int          got;
    int          i;
    logic        eot;
    logic [20:0] cp;
    logic [7:0]  b;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      kind = $urandom_range(11);
      eot  = ($urandom_range(9) == 0);
      case (kind)
        0, 1, 2: send_char(21'($urandom_range(127)), 1, eot);
        3: send_char(21'($urandom_range(2047)), 2, eot);
        4: begin
          if ($urandom_range(1)) send_char(21'h04E00 + 21'($urandom_range(20991)), 3, eot);
          else send_char(21'h03000 + 21'($urandom_range(255)), 3, eot);
        end
        5, 6: send_char(pick_near_edge(), ($urandom_range(1) ? 3 : 4), eot);
        7: send_char(21'($urandom_range(65535)), 3, eot);
        8: begin
          if ($urandom_range(1)) send_char(21'h1FA10 + 21'($urandom_range(65535)), 4, eot);
          else send_char(21'($urandom), 4, eot);
        end
        9: begin
          b = 8'($urandom);
          send_byte(b, eot);
        end
        default: begin
          // lead, too few continuations, then either a breaking byte or end of text
          len = $urandom_range(4, 2);
          got = $urandom_range(len - 2);
          cp  = 21'($urandom);
          case (len)
            2: send_byte({3'b110, cp[4:0]}, 1'b0);
            3: send_byte({4'b1110, cp[3:0]}, 1'b0);
            default: send_byte({5'b11110, cp[2:0]}, 1'b0);
          endcase
          for (i = 0; i < got; i++)
            send_byte({2'b10, 6'($urandom)}, (i == got - 1) && eot);
          if (!(eot && got > 0)) begin
            b = 8'($urandom);
            if (b[7:6] == 2'b10) b[6] = 1'b1;
            send_byte(b, eot);
          end
        end
      endcase
    end
  endtask

  task automatic test_edge_bytes();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    send_byte(8'h00, 1'b0);
    send_byte(8'h5F, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_char(21'h000A0, 2, 1'b0);
    send_char(21'h04E00, 3, 1'b0);
    send_char(21'h1FFFFF, 4, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hF8, 1'b0);
    send_byte(8'hFF, 1'b0);
    // two continuations gathered, then broken: four units from one byte
    send_byte(8'hF0, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h41, 1'b0);
    // lead byte as the final byte of a text
    send_byte(8'hC3, 1'b1);
    // truncated at end of text
    send_byte(8'hE3, 1'b0);
    send_byte(8'hBF, 1'b1);
    send_byte(8'h41, 1'b0);
    send_char(21'h2FA1F, 4, 1'b1);
    drain_units();
  endtask

  task automatic test_back_to_back();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    send_random_text(25);
    drain_units();
  endtask

  task automatic test_sender_gaps();
    send_gap_pct   = 45;
    recv_stall_pct = 0;
    send_random_text(30);
    drain_units();
  endtask

  task automatic test_receiver_stalls();
    send_gap_pct   = 0;
    recv_stall_pct = 45;
    send_random_text(30);
    drain_units();
  endtask

  task automatic test_both_idle();
    send_gap_pct   = 26;
    recv_stall_pct = 26;
    send_random_text(30);
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    send_random_text(25);
  endtask

  initial begin
    gather_val     = 21'd0;
    gather_len     = 3'd0;
    gather_cnt     = 2'd0;
    prior_cls      = CLS_SEP;
    text_start     = 1'b1;
    bad_units      = 0;
    bytes_sent     = 0;
    cycles         = 0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_edge_bytes();
    test_back_to_back();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    in_tvalid <= 1'b0;
    while (units_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (bad_units == 0 && units_due.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ----- utf8_word_segment_marker.f -----
+incdir+design
design/utf8ws_pkg.sv
design/utf8ws_decode.sv
design/utf8_word_segment_marker.sv
bench/tb_top.sv
